// ----- rtl/clema_pkg.sv -----
// Package for the call load average block: widths, limits, codes and the
// request and response types of the shared decay step unit.
// Depends on nothing; used by the step unit, the top and the testbench.
package clema_pkg;

  // Field widths
  localparam int COUNT_W    = 10;
  localparam int AVG_W      = 34;
  localparam int DECAY_W    = 24;
  localparam int TIME_W     = 32;
  localparam int CAP_W      = 8;
  localparam int INTERVAL_W = 16;

  // Fixed-point settings: decay factors are Q0.24, averages Q10.FRAC_BITS
  localparam int DECAY_FRAC = 24;
  localparam int FRAC_BITS  = 24;

  // Counter ceiling: the smaller of the call limit and the counter range
  localparam int MAX_CALLS = 1023;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    COUNT_W'((MAX_CALLS > COUNT_MAX) ? COUNT_MAX : MAX_CALLS);

  // Register reset values
  localparam logic [DECAY_W-1:0]    DECAY_SHORT_RST = 24'd16497596;
  localparam logic [DECAY_W-1:0]    DECAY_MID_RST   = 24'd16721292;
  localparam logic [DECAY_W-1:0]    DECAY_LONG_RST  = 24'd16758575;
  localparam logic [CAP_W-1:0]      CATCHUP_CAP_RST = 8'd60;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 16'd900;

  // Operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_TICK      = 2'd1,
    OP_CALL_UP   = 2'd2,
    OP_CALL_DOWN = 2'd3
  } op_e;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_DECAY_SHORT = 3'd0,
    REG_DECAY_MID   = 3'd1,
    REG_DECAY_LONG  = 3'd2,
    REG_CATCHUP_CAP = 3'd3,
    REG_INTERVAL    = 3'd4
  } reg_idx_e;

  // Request to the decay step unit; operands are held until done
  typedef struct packed {
    logic               go;
    logic [AVG_W-1:0]   avg;
    logic [DECAY_W-1:0] decay;
    logic [COUNT_W-1:0] count;
  } step_req_t;

  // Response from the decay step unit
  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] avg;
  } step_rsp_t;

endpackage

// ----- rtl/clema_step_unit.sv -----
// Decay step unit: one rounded exponential decay step of one average,
// built on a single shared 17 x 25 multiplier and a 64-bit accumulator.
// Depends on clema_pkg.
module clema_step_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clema_pkg::step_req_t req_i,
  output clema_pkg::step_rsp_t rsp_o
);

  localparam int HalfW = clema_pkg::AVG_W / 2;
  localparam int MulAW = clema_pkg::AVG_W - HalfW;
  localparam int MulBW = clema_pkg::DECAY_W + 1;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = 64;

  localparam logic [MulBW-1:0] DecayOne  = MulBW'(1) << clema_pkg::DECAY_FRAC;
  localparam logic [AccW-1:0]  RoundHalf = AccW'(1) << (clema_pkg::DECAY_FRAC - 1);

  typedef enum logic [3:0] {
    SU_IDLE    = 4'b0001,
    SU_MUL_HI  = 4'b0010,
    SU_MUL_CNT = 4'b0100,
    SU_SUM     = 4'b1000
  } su_state_e;

  su_state_e        state_q, state_d;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulBW-1:0] decay_comp;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [AccW-1:0]  sum;

  assign decay_comp = DecayOne - {1'b0, req_i.decay};

  // Operand selection for the shared multiplier: low half, high half, count
  always_comb begin
    case (state_q)
      SU_IDLE: begin
        mul_a = MulAW'(req_i.avg[HalfW-1:0]);
        mul_b = {1'b0, req_i.decay};
      end
      SU_MUL_HI: begin
        mul_a = req_i.avg[clema_pkg::AVG_W-1:HalfW];
        mul_b = {1'b0, req_i.decay};
      end
      SU_MUL_CNT: begin
        mul_a = MulAW'(req_i.count);
        mul_b = decay_comp;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  // Accumulation of the previous cycle's product at its weight
  always_comb begin
    case (state_q)
      SU_IDLE:    acc_d = RoundHalf;
      SU_MUL_HI:  acc_d = acc_q + AccW'(prod_q);
      SU_MUL_CNT: acc_d = acc_q + (AccW'(prod_q) << HalfW);
      default:    acc_d = acc_q;
    endcase
  end

  // The count term carries the average's fraction weight
  assign sum = acc_q + (AccW'(prod_q) << clema_pkg::FRAC_BITS);

  // Sequencer through the three partial products
  always_comb begin
    case (state_q)
      SU_IDLE:    state_d = req_i.go ? SU_MUL_HI : SU_IDLE;
      SU_MUL_HI:  state_d = SU_MUL_CNT;
      SU_MUL_CNT: state_d = SU_SUM;
      SU_SUM:     state_d = SU_IDLE;
      default:    state_d = SU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign rsp_o.done = (state_q == SU_SUM);
  assign rsp_o.avg  = sum[clema_pkg::AVG_W+clema_pkg::DECAY_FRAC-1:clema_pkg::DECAY_FRAC];

endmodule

// ----- rtl/call_load_average_ema_top.sv -----
// Top level of the call load average block: configuration registers,
// counter, time marks, the catch-up sequencer and the output register.
// Depends on clema_pkg and clema_step_unit.

// The block keeps an active-call counter and three exponential moving
// averages of it in unsigned Q10.24, and returns one result per input
// transfer. Start, call-up, call-down and a tick that is not later than the
// last one are finished in the cycle of the transfer and their result is
// registered at that edge. A later tick applies min(elapsed seconds,
// catchup_cap) decay steps, with a default cap of 60; in each step the
// three averages are decayed one after another, and the single shared
// 17 x 25 multiplier computes the three partial products of each one in
// turn. The input is not ready while such a tick runs. The reconcile
// check runs after the last step. Input tdata carries now_seconds and
// answered_count, tuser the operation; output tdata carries the averages
// and the counter, tuser the reconciled flag. Configuration is written
// over an APB-style port that is always ready.
module call_load_average_ema_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input stream
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic [47:0]   s_tdata_i,   // now_seconds[31:0], answered_count[41:32], zero pad
  input  logic [1:0]    s_tuser_i,   // operation[1:0]
  // Output stream
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [111:0]  m_tdata_o,   // load_short[33:0], load_mid[67:34],
                                     // load_long[101:68], active_now[111:102]
  output logic          m_tuser_o,   // reconciled[0]
  // Configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int CountW    = clema_pkg::COUNT_W;
  localparam int AvgW      = clema_pkg::AVG_W;
  localparam int DecayW    = clema_pkg::DECAY_W;
  localparam int TimeW     = clema_pkg::TIME_W;
  localparam int CapW      = clema_pkg::CAP_W;
  localparam int IntervalW = clema_pkg::INTERVAL_W;
  localparam logic [CountW-1:0] CountLimit = clema_pkg::COUNT_LIMIT;
  localparam logic [1:0] AvgLast = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DECAY = 3'b010,
    ST_RECON = 3'b100
  } top_state_e;

  // Configuration registers
  logic [DecayW-1:0]    decay_short_q, decay_mid_q, decay_long_q;
  logic [CapW-1:0]      cap_q;
  logic [IntervalW-1:0] interval_q;

  // Block state
  top_state_e        state_q;
  logic [CountW-1:0] active_q;
  logic [AvgW-1:0]   avg_short_q, avg_mid_q, avg_long_q;
  logic [TimeW-1:0]  last_tick_q, last_rec_q;
  logic [TimeW-1:0]  now_q;
  logic [CountW-1:0] ans_q;
  logic [CapW-1:0]   steps_q;
  logic [1:0]        sel_q;
  logic              busy_q;

  // Output register
  logic              out_valid_q;
  logic [AvgW-1:0]   out_short_q, out_mid_q, out_long_q;
  logic [CountW-1:0] out_active_q;
  logic              out_rec_q;

  // Input fields
  clema_pkg::op_e    op_in;
  logic [TimeW-1:0]  now_in;
  logic [CountW-1:0] ans_in;

  logic              s_xfer;
  logic              out_free;
  logic [TimeW:0]    tick_diff;
  logic              tick_later;
  logic [CapW-1:0]   steps_in;
  logic [CountW-1:0] count_next;
  logic [TimeW-1:0]  rec_elapsed;
  logic              rec_due;
  logic [CountW-1:0] ans_clamped;
  logic              cfg_wr;
  clema_pkg::reg_idx_e cfg_idx;

  clema_pkg::step_req_t step_req;
  clema_pkg::step_rsp_t step_rsp;

  assign op_in  = clema_pkg::op_e'(s_tuser_i);
  assign now_in = s_tdata_i[TimeW-1:0];
  assign ans_in = s_tdata_i[TimeW+CountW-1:TimeW];

  // Handshakes
  assign out_free   = !out_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE) && out_free;
  assign s_xfer     = s_tvalid_i && s_tready_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_idx    = clema_pkg::reg_idx_e'(paddr[4:2]);

  // Elapsed time since the last tick; the borrow tells whether it is later
  assign tick_diff  = {1'b0, now_in} - {1'b0, last_tick_q};
  assign tick_later = !tick_diff[TimeW] && (tick_diff[TimeW-1:0] != '0);
  assign steps_in   = ((tick_diff[TimeW-1:CapW] != '0) || (tick_diff[CapW-1:0] > cap_q))
                      ? cap_q : tick_diff[CapW-1:0];

  // Counter update for call transfers
  always_comb begin
    case (op_in)
      clema_pkg::OP_CALL_UP:
        count_next = (active_q < CountLimit) ? active_q + CountW'(1) : active_q;
      clema_pkg::OP_CALL_DOWN:
        count_next = (active_q != '0) ? active_q - CountW'(1) : active_q;
      default:
        count_next = active_q;
    endcase
  end

  // Reconcile check after the catch-up steps
  assign rec_elapsed = now_q - last_rec_q;
  assign rec_due     = rec_elapsed >= TimeW'(interval_q);
  assign ans_clamped = (ans_q > CountLimit) ? CountLimit : ans_q;

  // Operands for the step unit, chosen by the average being stepped
  always_comb begin
    step_req.go    = (state_q == ST_DECAY) && !busy_q && (steps_q != '0);
    step_req.count = active_q;
    case (sel_q)
      2'd0: begin
        step_req.avg   = avg_short_q;
        step_req.decay = decay_short_q;
      end
      2'd1: begin
        step_req.avg   = avg_mid_q;
        step_req.decay = decay_mid_q;
      end
      default: begin
        step_req.avg   = avg_long_q;
        step_req.decay = decay_long_q;
      end
    endcase
  end

  clema_step_unit u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (step_req),
    .rsp_o  (step_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_short_q <= clema_pkg::DECAY_SHORT_RST;
      decay_mid_q   <= clema_pkg::DECAY_MID_RST;
      decay_long_q  <= clema_pkg::DECAY_LONG_RST;
      cap_q         <= clema_pkg::CATCHUP_CAP_RST;
      interval_q    <= clema_pkg::INTERVAL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        clema_pkg::REG_DECAY_SHORT: decay_short_q <= pwdata[DecayW-1:0];
        clema_pkg::REG_DECAY_MID:   decay_mid_q   <= pwdata[DecayW-1:0];
        clema_pkg::REG_DECAY_LONG:  decay_long_q  <= pwdata[DecayW-1:0];
        clema_pkg::REG_CATCHUP_CAP: cap_q         <= pwdata[CapW-1:0];
        clema_pkg::REG_INTERVAL:    interval_q    <= pwdata[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    case (cfg_idx)
      clema_pkg::REG_DECAY_SHORT: prdata = 32'(decay_short_q);
      clema_pkg::REG_DECAY_MID:   prdata = 32'(decay_mid_q);
      clema_pkg::REG_DECAY_LONG:  prdata = 32'(decay_long_q);
      clema_pkg::REG_CATCHUP_CAP: prdata = 32'(cap_q);
      clema_pkg::REG_INTERVAL:    prdata = 32'(interval_q);
      default:                    prdata = '0;
    endcase
  end

  // Sequencer, counter, averages and time marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      avg_short_q <= '0;
      avg_mid_q   <= '0;
      avg_long_q  <= '0;
      last_tick_q <= '0;
      last_rec_q  <= '0;
      steps_q     <= '0;
      sel_q       <= '0;
      busy_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_xfer) begin
            case (op_in)
              clema_pkg::OP_START: begin
                last_tick_q <= now_in;
                last_rec_q  <= now_in;
              end
              clema_pkg::OP_TICK: begin
                if (tick_later) begin
                  last_tick_q <= now_in;
                  steps_q     <= steps_in;
                  sel_q       <= '0;
                  state_q     <= ST_DECAY;
                end
              end
              default: active_q <= count_next;
            endcase
          end
        end
        ST_DECAY: begin
          if (step_req.go) begin
            busy_q <= 1'b1;
          end
          if (step_rsp.done) begin
            busy_q <= 1'b0;
            case (sel_q)
              2'd0:    avg_short_q <= step_rsp.avg;
              2'd1:    avg_mid_q   <= step_rsp.avg;
              default: avg_long_q  <= step_rsp.avg;
            endcase
            if (sel_q == AvgLast) begin
              sel_q   <= '0;
              steps_q <= steps_q - CapW'(1);
            end else begin
              sel_q <= sel_q + 2'd1;
            end
          end
          if (!busy_q && (steps_q == '0)) begin
            state_q <= ST_RECON;
          end
        end
        ST_RECON: begin
          if (out_free) begin
            if (rec_due) begin
              active_q   <= ans_clamped;
              last_rec_q <= now_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Tick operands held for the reconcile check
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      now_q <= now_in;
      ans_q <= ans_in;
    end
  end

  // Output register: loaded when an item finishes, cleared by a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((s_xfer && !(op_in == clema_pkg::OP_TICK && tick_later)) ||
                 (state_q == ST_RECON && out_free)) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer && !(op_in == clema_pkg::OP_TICK && tick_later)) begin
      out_short_q  <= avg_short_q;
      out_mid_q    <= avg_mid_q;
      out_long_q   <= avg_long_q;
      out_active_q <= count_next;
      out_rec_q    <= 1'b0;
    end else if (state_q == ST_RECON && out_free) begin
      out_short_q  <= avg_short_q;
      out_mid_q    <= avg_mid_q;
      out_long_q   <= avg_long_q;
      out_active_q <= rec_due ? ans_clamped : active_q;
      out_rec_q    <= rec_due;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_active_q, out_long_q, out_mid_q, out_short_q};
  assign m_tuser_o  = out_rec_q;

`ifndef SYNTHESIS
  // The counter never passes its ceiling
  assert property (@(posedge clk_i) disable iff (!rst_ni) active_q <= CountLimit)
    else $error("active call counter above its limit");

  // The step unit only works while the catch-up sequence runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> (state_q == ST_DECAY))
    else $error("step unit busy outside the catch-up sequence");

  // A step result only arrives for a step that was launched
  assert property (@(posedge clk_i) disable iff (!rst_ni) step_rsp.done |-> busy_q)
    else $error("step result without a launched step");

  // Non-tick transfers give their result at the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (s_xfer && (op_in != clema_pkg::OP_TICK)) |=> out_valid_q)
    else $error("result of an immediate item was not registered");

  // The remaining step count never exceeds the catch-up cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_DECAY) |-> (steps_q <= cap_q))
    else $error("catch-up step count above the cap");
`endif

endmodule

// ----- dv/clema_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the call load average block: watches the input, output and
// configuration channels, predicts each result and compares it field by field.
// Depends on clema_pkg for widths, limits, operation codes and register indexes.
module clema_checker
  import clema_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream as seen at the block
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [47:0]  s_tdata_i,   // now_seconds[31:0], answered_count[41:32], zero pad
  input  logic [1:0]   s_tuser_i,   // operation[1:0]
  // Output stream as seen at the block
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [111:0] m_tdata_i,   // load_short[33:0], load_mid[67:34],
                                    // load_long[101:68], active_now[111:102]
  input  logic         m_tuser_i,   // reconciled[0]
  // Configuration port
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [4:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  input  logic         pready_i,
  // Verdict inputs for the testbench top
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  typedef struct packed {
    logic [AVG_W-1:0]   load_short;
    logic [AVG_W-1:0]   load_mid;
    logic [AVG_W-1:0]   load_long;
    logic [COUNT_W-1:0] active_now;
    logic               reconciled;
  } load_result_t;

  // Shadow copy of the configuration registers.
  logic [DECAY_W-1:0]    cfg_decay_short;
  logic [DECAY_W-1:0]    cfg_decay_mid;
  logic [DECAY_W-1:0]    cfg_decay_long;
  logic [CAP_W-1:0]      cfg_cap;
  logic [INTERVAL_W-1:0] cfg_interval;

  // Shadow copy of the block's state.
  logic [COUNT_W-1:0] calls_active;
  logic [AVG_W-1:0]   ema_short;
  logic [AVG_W-1:0]   ema_mid;
  logic [AVG_W-1:0]   ema_long;
  logic [TIME_W-1:0]  tick_mark;
  logic [TIME_W-1:0]  recon_mark;

  load_result_t expected_loads[$];
  load_result_t got_load;
  load_result_t want_load;

  // One rounded decay step of an average towards the counter value.
  function automatic logic [AVG_W-1:0] decay_once(input logic [AVG_W-1:0] avg,
                                                  input logic [DECAY_W-1:0] factor,
                                                  input logic [COUNT_W-1:0] count);
    logic [63:0] acc;
    acc = 64'(avg) * 64'(factor)
        + (64'(count) << FRAC_BITS) * ((64'd1 << DECAY_FRAC) - 64'(factor))
        + (64'd1 << (DECAY_FRAC - 1));
    return AVG_W'(acc >> DECAY_FRAC);
  endfunction

  // Applies one input transfer to the shadow state and returns its result.
  function automatic load_result_t predict_load(input op_e op,
                                                input logic [TIME_W-1:0] now,
                                                input logic [COUNT_W-1:0] answered);
    load_result_t      res;
    logic [TIME_W-1:0] steps;
    logic [TIME_W-1:0] elapsed;
    int unsigned       n;
    res = '0;
    case (op)
      OP_START: begin
        tick_mark  = now;
        recon_mark = now;
      end
      OP_TICK: begin
        if (now > tick_mark) begin
          steps = now - tick_mark;
          if (steps > TIME_W'(cfg_cap)) steps = TIME_W'(cfg_cap);
          for (n = 0; n < steps; n++) begin
            ema_short = decay_once(ema_short, cfg_decay_short, calls_active);
            ema_mid   = decay_once(ema_mid, cfg_decay_mid, calls_active);
            ema_long  = decay_once(ema_long, cfg_decay_long, calls_active);
          end
          tick_mark = now;
          // The interval is measured modulo 2^32.
          elapsed = now - recon_mark;
          if (elapsed >= TIME_W'(cfg_interval)) begin
            calls_active   = (answered > COUNT_LIMIT) ? COUNT_LIMIT : answered;
            recon_mark     = now;
            res.reconciled = 1'b1;
          end
        end
      end
      OP_CALL_UP: begin
        if (calls_active < COUNT_LIMIT) calls_active = calls_active + 1'b1;
      end
      default: begin
        if (calls_active != '0) calls_active = calls_active - 1'b1;
      end
    endcase
    res.load_short = ema_short;
    res.load_mid   = ema_mid;
    res.load_long  = ema_long;
    res.active_now = calls_active;
    return res;
  endfunction

  // Counts a failure and reports the first ten of them.
  task automatic flag_result(input string what, input load_result_t want,
                             input load_result_t got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("%0t load check: %s: expected short=%h mid=%h long=%h active=%0d rec=%0b",
               $time, what, want.load_short, want.load_mid, want.load_long,
               want.active_now, want.reconciled,
               "; got short=%h mid=%h long=%h active=%0d rec=%0b",
               got.load_short, got.load_mid, got.load_long, got.active_now,
               got.reconciled);
  endtask

  // Channel monitor: register writes, result transfers, then input transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_decay_short = DECAY_SHORT_RST;
      cfg_decay_mid   = DECAY_MID_RST;
      cfg_decay_long  = DECAY_LONG_RST;
      cfg_cap         = CATCHUP_CAP_RST;
      cfg_interval    = INTERVAL_RST;
      calls_active    = '0;
      ema_short       = '0;
      ema_mid         = '0;
      ema_long        = '0;
      tick_mark       = '0;
      recon_mark      = '0;
      expected_loads.delete();
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[4:2]))
          REG_DECAY_SHORT: cfg_decay_short = pwdata_i[DECAY_W-1:0];
          REG_DECAY_MID:   cfg_decay_mid   = pwdata_i[DECAY_W-1:0];
          REG_DECAY_LONG:  cfg_decay_long  = pwdata_i[DECAY_W-1:0];
          REG_CATCHUP_CAP: cfg_cap         = pwdata_i[CAP_W-1:0];
          REG_INTERVAL:    cfg_interval    = pwdata_i[INTERVAL_W-1:0];
          default: ;
        endcase
      end

      // A result transfer is matched against the oldest expectation.
      if (m_tvalid_i && m_tready_i) begin
        got_load.load_short = m_tdata_i[33:0];
        got_load.load_mid   = m_tdata_i[67:34];
        got_load.load_long  = m_tdata_i[101:68];
        got_load.active_now = m_tdata_i[111:102];
        got_load.reconciled = m_tuser_i;
        if (expected_loads.size() == 0) begin
          flag_result("result with none expected", '0, got_load);
        end else begin
          want_load = expected_loads.pop_front();
          if (got_load.load_short !== want_load.load_short ||
              got_load.load_mid   !== want_load.load_mid   ||
              got_load.load_long  !== want_load.load_long  ||
              got_load.active_now !== want_load.active_now ||
              got_load.reconciled !== want_load.reconciled)
            flag_result("mismatch", want_load, got_load);
        end
      end

      if (s_tvalid_i && s_tready_i)
        expected_loads.push_back(predict_load(op_e'(s_tuser_i), s_tdata_i[31:0],
                                              s_tdata_i[41:32]));

      pending_o = expected_loads.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the call load average block: clock, reset, stimulus,
// configuration phases and the final verdict.
// Depends on clema_pkg, call_load_average_ema_top and clema_checker.
module tb_top;
  import clema_pkg::*;

  typedef enum int {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_SPARSE,
    RDY_MOSTLY
  } ready_mode_e;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_tvalid_i;
  logic         s_tready_o;
  logic [47:0]  s_tdata_i;
  logic [1:0]   s_tuser_i;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [111:0] m_tdata_o;
  logic         m_tuser_o;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       burst_left;
  logic [TIME_W-1:0] wall_time;
  ready_mode_e       ready_mode;
  int unsigned       ready_left = 0;

  always #1 clk_i = ~clk_i;

  call_load_average_ema_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  clema_checker u_load_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .m_tuser_i    (m_tuser_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The receiver switches between stall patterns in stretches of random length.
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(10, 150);
    end
    ready_left--;
    case (ready_mode)
      RDY_ALWAYS: m_tready_i <= 1'b1;
      RDY_HALF:   m_tready_i <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: m_tready_i <= ($urandom_range(0, 3) == 0);
      default:    m_tready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Presents one item and holds it until its transfer; called at a falling edge.
  task automatic send_item(input op_e op, input logic [TIME_W-1:0] now,
                           input logic [COUNT_W-1:0] answered);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      if (gap != 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {6'd0, answered, now};
    s_tuser_i  <= op;
    do @(posedge clk_i); while (!s_tready_o);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [DECAY_W-1:0] d_short,
                            input logic [DECAY_W-1:0] d_mid,
                            input logic [DECAY_W-1:0] d_long,
                            input logic [CAP_W-1:0] cap,
                            input logic [INTERVAL_W-1:0] interval);
    write_reg(REG_DECAY_SHORT, 32'(d_short));
    write_reg(REG_DECAY_MID, 32'(d_mid));
    write_reg(REG_DECAY_LONG, 32'(d_long));
    write_reg(REG_CATCHUP_CAP, 32'(cap));
    write_reg(REG_INTERVAL, 32'(interval));
  endtask

  // Decay factors are close to one, as in use, half the time, and anywhere otherwise.
  function automatic logic [DECAY_W-1:0] pick_decay();
    if ($urandom_range(0, 1) == 0) return DECAY_W'($urandom_range(16000000, 16777215));
    return DECAY_W'($urandom);
  endfunction

  // Mostly well-formed traffic: starts, ticks a few seconds apart and call
  // changes, with ticks that go backwards and large jumps mixed in.
  task automatic random_item();
    int unsigned       pick;
    int unsigned       roll;
    logic [COUNT_W-1:0] answered;
    answered = COUNT_W'($urandom_range(0, 1023));
    pick     = $urandom_range(0, 99);
    if (pick < 5) begin
      wall_time = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom)
                                              : wall_time + $urandom_range(0, 5);
      send_item(OP_START, wall_time, answered);
    end else if (pick < 45) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_item(OP_TICK, wall_time - $urandom_range(0, 20), answered);
      end else begin
        if (roll < 70)      wall_time = wall_time + $urandom_range(1, 3);
        else if (roll < 92) wall_time = wall_time + $urandom_range(4, 70);
        else                wall_time = wall_time + $urandom_range(71, 5000);
        send_item(OP_TICK, wall_time, answered);
      end
    end else if (pick < 75) begin
      send_item(OP_CALL_UP, TIME_W'($urandom), answered);
    end else begin
      send_item(OP_CALL_DOWN, TIME_W'($urandom), answered);
    end
  endtask

  // Run limit, far beyond the slowest correct run.
  initial begin
    #100_000_000;
    $display("[call_load_average_ema_top] ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int phase;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    s_tuser_i  = OP_START;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_ni     = 1'b0;
    burst_left = 0;
    wall_time  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset configuration.
    send_item(OP_CALL_DOWN, 32'd0, 10'd0);              // counter floors at zero
    send_item(OP_CALL_UP, 32'hFFFF_FFFF, 10'h3FF);      // unused fields ignored
    send_item(OP_TICK, 32'd0, 10'd0);                   // not later than the mark
    send_item(OP_START, 32'd100, 10'd0);
    repeat (3) send_item(OP_CALL_UP, 32'd0, 10'd0);
    send_item(OP_TICK, 32'd101, 10'd5);                 // single decay step
    send_item(OP_TICK, 32'd101, 10'd5);                 // same second
    send_item(OP_TICK, 32'd50, 10'd5);                  // earlier second
    send_item(OP_TICK, 32'd1100, 10'h3FF);              // capped catch-up, reconcile
    send_item(OP_CALL_UP, 32'd0, 10'd0);                // saturates at the limit
    send_item(OP_TICK, 32'd1103, 10'd0);                // decay towards a full counter
    send_item(OP_CALL_DOWN, 32'd0, 10'd0);
    send_item(OP_START, 32'hFFFF_FF00, 10'd0);
    send_item(OP_TICK, 32'hFFFF_FFFF, 10'h2AA);         // top of the time range
    send_item(OP_TICK, 32'd3, 10'h155);                 // wrapped time is not later
    send_item(OP_START, 32'h5555_5555, 10'h155);
    send_item(OP_TICK, 32'hAAAA_AAAA, 10'h2AA);         // huge gap, reconcile
    send_item(OP_TICK, 32'hAAAA_AAAB, 10'h155);
    wall_time = 32'hAAAA_AAAB;

    // Random part over several configurations, each set while the block is idle.
    for (phase = 0; phase < 8; phase++) begin
      drain_results();
      case (phase)
        0: ;  // reset configuration
        1: set_config('0, '0, '0, 8'd1, 16'd1);
        2: set_config('1, '1, '1, 8'd255, 16'hFFFF);
        3: set_config(pick_decay(), pick_decay(), pick_decay(), 8'd0, 16'd0);
        default: set_config(pick_decay(), pick_decay(), pick_decay(),
                            CAP_W'($urandom_range(0, 80)),
                            ($urandom_range(0, 3) == 0) ? INTERVAL_W'($urandom)
                                                        : INTERVAL_W'($urandom_range(0, 300)));
      endcase
      repeat (210) random_item();
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[call_load_average_ema_top] OK");
    end else begin
      $display("[call_load_average_ema_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- call_load_average_ema_top.f -----
rtl/clema_pkg.sv
rtl/clema_step_unit.sv
rtl/call_load_average_ema_top.sv
dv/clema_checker.sv
dv/tb_top.sv
